// File: design/itpc_pkg.sv
// Shared types, token codes and the precedence function for the infix to postfix converter.
// Depends on nothing; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package itpc_pkg;

   // Default depth of the operator stack, and the most words one token may produce
   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 16;

   localparam int OP_W   = 4;
   localparam int KIND_W = 3;

   // Input token codes
   localparam logic [OP_W-1:0] OP_OPERAND = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 4'd1;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL     = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV     = 4'd4;
   localparam logic [OP_W-1:0] OP_POW     = 4'd5;
   localparam logic [OP_W-1:0] OP_OPEN    = 4'd6;
   localparam logic [OP_W-1:0] OP_CLOSE   = 4'd7;
   localparam logic [OP_W-1:0] OP_END     = 4'd8;

   // Output token kinds, also the codes held on the stack
   localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUB     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MUL     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIV     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_POW     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [31:0]     operand_value;
      logic            operand_is_name;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [31:0]       token_value;
      logic              token_is_name;
      logic              stack_overflowed;
      logic              last_of_flush;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EVAL
   } state_type;

   // Binding strength; '(' and anything else rank below every operator
   function automatic logic [1:0] prec_of(input logic [KIND_W-1:0] kind);
      logic [1:0] prec;
      case (kind) inside
         KIND_ADD, KIND_SUB: prec = 2'd1;
         KIND_MUL, KIND_DIV: prec = 2'd2;
         KIND_POW:           prec = 2'd3;
         default:            prec = 2'd0;
      endcase
      return prec;
   endfunction

endpackage

// File: design/itpc_stack_mem.sv
// Operator stack storage: one write port, one read port with registered read data.
// Depends on itpc_pkg for the kind width.
`timescale 1ns / 1ps

module itpc_stack_mem #(
   parameter int DEPTH = itpc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [itpc_pkg::KIND_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [itpc_pkg::KIND_W-1:0]  rd_data
);

   logic [itpc_pkg::KIND_W-1:0] mem [DEPTH];
   logic [itpc_pkg::KIND_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter.
// Depends on itpc_pkg and instantiates itpc_stack_mem.
`timescale 1ns / 1ps

// Infix tokens enter on the req_ channel one word at a time and postfix tokens
// leave on the rsp_ channel in order. Operands pass straight through, '(' is
// stacked, ')' pops operators up to its '(' and drops it, an operator pops every
// stacked operator that binds at least as tightly and is then stacked, and end
// flushes the stack, flagging its final word with last_of_flush and then clearing
// the sticky overflow flag. The operator stack lives in a synchronous memory of
// STACK_DEPTH entries with registered read data; the stack count and the
// overflow flag sit in flip-flops. One word is worked on at a time: the next
// word is taken only once the current one is done. An operand, a '(' or any
// token that meets an empty stack is handled in the dispatch state. A ')',
// operator or end that meets a non-empty stack first reads the stack top; its
// work ends when its last pop ends it (an end, a pop that empties the stack or
// one that reaches the word limit) or when a stack read finds nothing more to
// pop. After the first stack read, the read of the next entry overlaps the pop
// of the current one, giving one pop per cycle while the result channel does
// not stall. One token never yields more than MAX_RESULTS words. No clearing
// pass is needed after reset: entries above the count are never read.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itpc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itpc_pkg::rsp_word_type rsp_word
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int POP_W  = $clog2(itpc_pkg::MAX_RESULTS + 1);

   // Control registers
   itpc_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [POP_W-1:0]       pops_ff, pops_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   itpc_pkg::req_word_type tok_ff, tok_in;
   itpc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Stack memory port
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [itpc_pkg::KIND_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [ADDR_W-1:0]           mem_rd_addr;
   logic [itpc_pkg::KIND_W-1:0] mem_rd_data;

   // Decisions of the current cycle
   logic                   rsp_load;
   itpc_pkg::rsp_word_type load_word;
   logic                   out_free;
   logic                   to_eval;
   logic                   done;
   logic                   do_push;
   logic                   is_operand, is_open, is_close, is_end, is_oper;
   logic [itpc_pkg::KIND_W-1:0] tok_kind;
   logic                   want_pop;
   logic                   last_pop;
   logic [CNT_W-1:0]       cnt_less1, cnt_less2;

   itpc_stack_mem #(
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The output register can take a word when empty or when its word leaves now
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != itpc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign tok_kind  = tok_ff.operation[itpc_pkg::KIND_W-1:0];
   assign cnt_less1 = count_ff - CNT_W'(1);
   assign cnt_less2 = count_ff - CNT_W'(2);

   // Classify the held token; unknown codes travel as operands
   always_comb begin
      is_operand = 1'b0;
      is_open    = 1'b0;
      is_close   = 1'b0;
      is_end     = 1'b0;
      is_oper    = 1'b0;
      case (tok_ff.operation) inside
         itpc_pkg::OP_ADD, itpc_pkg::OP_SUB, itpc_pkg::OP_MUL,
         itpc_pkg::OP_DIV, itpc_pkg::OP_POW: is_oper    = 1'b1;
         itpc_pkg::OP_OPEN:                  is_open    = 1'b1;
         itpc_pkg::OP_CLOSE:                 is_close   = 1'b1;
         itpc_pkg::OP_END:                   is_end     = 1'b1;
         default:                            is_operand = 1'b1;
      endcase
   end

   // Pop test against the freshly read stack top
   assign want_pop = is_end
                  || (is_close && (mem_rd_data != itpc_pkg::KIND_OPEN))
                  || (is_oper && (itpc_pkg::prec_of(tok_kind)
                                  <= itpc_pkg::prec_of(mem_rd_data)));
   // This pop empties the stack or reaches the per-token word limit
   assign last_pop = (count_ff == CNT_W'(1))
                  || (pops_ff == POP_W'(itpc_pkg::MAX_RESULTS - 1));

   // Datapath and memory control
   always_comb begin
      tok_in      = tok_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      pops_in     = pops_ff;
      rsp_load    = 1'b0;
      load_word   = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = tok_kind;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_less1[ADDR_W-1:0];
      to_eval     = 1'b0;
      done        = 1'b0;
      do_push     = 1'b0;

      unique case (state_ff)
         itpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               tok_in = req_word;
            end
         end

         itpc_pkg::ST_DISPATCH: begin
            pops_in = '0;
            if (is_operand) begin
               // Pass the operand through once the output register is free
               if (out_free) begin
                  rsp_load                   = 1'b1;
                  load_word.token_kind       = itpc_pkg::KIND_OPERAND;
                  load_word.token_value      = tok_ff.operand_value;
                  load_word.token_is_name    = tok_ff.operand_is_name;
                  load_word.stack_overflowed = overflow_ff;
                  done                       = 1'b1;
               end
            end else if (is_open) begin
               do_push = 1'b1;
               done    = 1'b1;
            end else if (count_ff == '0) begin
               // Nothing to pop: stack an operator, clear the flag on end
               do_push = is_oper;
               if (is_end) begin
                  overflow_in = 1'b0;
               end
               done = 1'b1;
            end else begin
               // Fetch the stack top
               mem_rd_en = 1'b1;
               to_eval   = 1'b1;
            end
         end

         itpc_pkg::ST_EVAL: begin
            if (want_pop) begin
               if (out_free) begin
                  rsp_load                   = 1'b1;
                  load_word.token_kind       = mem_rd_data;
                  load_word.stack_overflowed = overflow_ff;
                  load_word.last_of_flush    = is_end && last_pop;
                  count_in                   = cnt_less1;
                  pops_in                    = pops_ff + POP_W'(1);
                  if (last_pop) begin
                     done = 1'b1;
                     if (is_oper) begin
                        // Stack the operator in the slot just freed
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cnt_less1[ADDR_W-1:0];
                        count_in    = count_ff;
                     end
                     if (is_end) begin
                        count_in    = '0;
                        overflow_in = 1'b0;
                     end
                  end else begin
                     // Overlap the read of the next entry with this pop
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = cnt_less2[ADDR_W-1:0];
                  end
               end
            end else begin
               done = 1'b1;
               if (is_close) begin
                  // Drop the matching '('
                  count_in = cnt_less1;
               end else begin
                  do_push = 1'b1;
               end
            end
         end

         default: begin
         end
      endcase

      // Push at the current count, or mark the overflow when full
      if (do_push) begin
         if (count_ff == CNT_W'(STACK_DEPTH)) begin
            overflow_in = 1'b1;
         end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = count_ff[ADDR_W-1:0];
            count_in    = count_ff + CNT_W'(1);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = itpc_pkg::ST_DISPATCH;
            end
         end
         itpc_pkg::ST_DISPATCH: begin
            if (to_eval) begin
               state_in = itpc_pkg::ST_EVAL;
            end else if (done) begin
               state_in = itpc_pkg::ST_IDLE;
            end
         end
         itpc_pkg::ST_EVAL: begin
            if (done) begin
               state_in = itpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itpc_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: load a new word, or drop the old one once taken
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_word_in  = load_word;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itpc_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         pops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         pops_ff      <= pops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff      <= tok_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_eval_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itpc_pkg::ST_EVAL) |-> (count_ff != '0))
      else $error("stack top examined on an empty stack");

   a_pop_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itpc_pkg::ST_EVAL) |-> (pops_ff < POP_W'(itpc_pkg::MAX_RESULTS)))
      else $error("word limit per token exceeded");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && load_word.last_of_flush) |=> (count_ff == '0 && !overflow_ff))
      else $error("end token left stack or flag set");

   a_overflow_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> ($past(count_ff) == CNT_W'(STACK_DEPTH)))
      else $error("overflow flag set without a full stack");
`endif

endmodule
